[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define S2DT_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("s2dt assertion failed");

// Implication form of the assertion above.
`define S2DT_ASSERT_IMP(name, clk, rst, ante, cons) \
  `S2DT_ASSERT(name, clk, rst, (ante) |-> (cons))

`endif

[rtl/s2dt_pkg.sv]
// Shared types and character constants for the decimal text converter.
`timescale 1ns / 1ps
package s2dt_pkg;

  typedef logic [7:0] char_t;

  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;
  localparam char_t CHAR_MINUS = 8'h2D;

  // Double-dabble adjust: digits at or above this get the offset added.
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

endpackage

[rtl/s2dt_if.sv]
// Valid/ready channel interfaces for input integers and output characters.
`timescale 1ns / 1ps
interface s2dt_value_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface s2dt_char_if import s2dt_pkg::*;;
  logic  valid;
  logic  ready;
  char_t char_out;
  logic  last_char;

  modport source (output valid, output char_out, output last_char, input ready);
  modport sink (input valid, input char_out, input last_char, output ready);
endinterface

[rtl/s2dt_bcd.sv]
// Bit-serial binary to BCD converter (shift and add-3).
`timescale 1ns / 1ps
module s2dt_bcd import s2dt_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int DIGITS      = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] mag,
  output logic                   done,
  output logic [4*DIGITS-1:0]    bcd
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH-1:0] shreg;
  logic [4*DIGITS-1:0]    adj;

  // Add 3 to every digit of 5 or more before the next shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= BCD_ADJ_MIN) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + BCD_ADJ;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shreg <= mag;
        bcd   <= '0;
        cnt   <= CNT_W'(VALUE_WIDTH);
        busy  <= 1'b1;
      end else if (busy) begin
        bcd   <= {adj[4*DIGITS-2:0], shreg[VALUE_WIDTH-1]};
        shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
        cnt   <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/signed_integer_to_decimal_text.sv]
// After accept, the magnitude goes through the bit-serial BCD converter and a leading-zero strip.
// Then one character per cycle while the sink is ready (sign, then digits, no leading zeros).
// Integers are not overlapped: the BCD shift (one input bit per cycle) and the
// one-digit-per-cycle leading-zero strip run first, and the next integer is taken once
// the last character is loaded into the output register. Synchronous active-high reset idles all.
`timescale 1ns / 1ps
module signed_integer_to_decimal_text import s2dt_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  s2dt_value_if.sink   value_ch,
  s2dt_char_if.source  char_ch
);

  // Decimal digits needed for any VALUE_WIDTH-bit unsigned magnitude.
  localparam int DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int DCNT_W = $clog2(DIGITS + 1);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_STRIP, S_EMIT} state_t;

  state_t                 state;
  logic                   sign_pend;   // a '-' still has to go out
  logic [4*DIGITS-1:0]    digs;        // BCD digits, leading digit at the top
  logic [DCNT_W-1:0]      dcnt;        // digits left in digs
  logic                   out_valid;
  char_t                  out_char;
  logic                   out_last;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   start;
  logic                   conv_done;
  logic [4*DIGITS-1:0]    bcd;
  logic [3:0]             top_dig;
  logic                   emit_ok;

  // Keep only the low VALUE_WIDTH bits; the top one of those is the sign.
  // Negating the most negative value yields 2^(VALUE_WIDTH-1) as unsigned.
  assign raw     = value_ch.value[VALUE_WIDTH-1:0];
  assign mag     = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

  assign value_ch.ready = (state == S_IDLE);
  assign start          = value_ch.valid && value_ch.ready;

  assign top_dig = digs[4*DIGITS-1 -: 4];
  // Output register is free, or is being drained this cycle.
  assign emit_ok = !out_valid || char_ch.ready;

  assign char_ch.valid     = out_valid;
  assign char_ch.char_out  = out_char;
  assign char_ch.last_char = out_last;

  s2dt_bcd #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGITS      (DIGITS)
  ) u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sign_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the held character once the sink takes it; in S_EMIT the
      // refill below decides the next value instead.
      if (out_valid && char_ch.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            sign_pend <= raw[VALUE_WIDTH-1];
            state     <= S_CONV;
          end
        end

        S_CONV: begin
          // Hold until the serial converter has shifted in every bit.
          if (conv_done) begin
            digs  <= bcd;
            dcnt  <= DCNT_W'(DIGITS);
            state <= S_STRIP;
          end
        end

        S_STRIP: begin
          // Advance past leading zeros, one digit per cycle; a lone zero stays.
          if (top_dig == 4'd0 && dcnt != DCNT_W'(1)) begin
            digs <= {digs[4*DIGITS-5:0], 4'd0};
            dcnt <= dcnt - DCNT_W'(1);
          end else begin
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (emit_ok) begin
            out_valid <= 1'b1;
            if (sign_pend) begin
              out_char  <= CHAR_MINUS;
              out_last  <= 1'b0;
              sign_pend <= 1'b0;
            end else begin
              out_char <= CHAR_ZERO + {4'd0, top_dig};
              out_last <= (dcnt == DCNT_W'(1));
              digs     <= {digs[4*DIGITS-5:0], 4'd0};
              dcnt     <= dcnt - DCNT_W'(1);
              // Last digit loaded: free the input side right away.
              if (dcnt == DCNT_W'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/s2dt_checker.sv]
// Port-level checker for the decimal text converter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module s2dt_checker import s2dt_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input char_t char_out,
  input logic  last_char
);

  `S2DT_ASSERT_IMP(a_out_hold, clk, rst, out_valid && !out_ready, ##1 out_valid)
  `S2DT_ASSERT_IMP(a_out_stable, clk, rst, out_valid && !out_ready,
                   ##1 ($stable(char_out) && $stable(last_char)))
  `S2DT_ASSERT_IMP(a_char_legal, clk, rst, out_valid,
                   char_out == CHAR_MINUS || (char_out >= CHAR_ZERO && char_out <= CHAR_NINE))
  `S2DT_ASSERT_IMP(a_minus_not_last, clk, rst, out_valid && char_out == CHAR_MINUS, !last_char)
  `S2DT_ASSERT_IMP(a_busy_after_accept, clk, rst, in_valid && in_ready, ##1 !in_ready)

endmodule

bind signed_integer_to_decimal_text s2dt_checker u_s2dt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (value_ch.valid),
  .in_ready  (value_ch.ready),
  .out_valid (char_ch.valid),
  .out_ready (char_ch.ready),
  .char_out  (char_ch.char_out),
  .last_char (char_ch.last_char)
);
